>>> hw/rtl/spq_pkg.sv
package spq_pkg;

  // job record as kept in a slot: priority on top, then the payload
  localparam int PRIO_W    = 4;
  localparam int PROD_W    = 8;
  localparam int PROC_W    = 22;
  localparam int CTIME_W   = 4;
  localparam int JOB_W     = 20;
  localparam int PAYLOAD_W = PROD_W + PROC_W + CTIME_W + JOB_W;
  localparam int REC_W     = PRIO_W + PAYLOAD_W;
  localparam int OCC_W     = 4;
  localparam int STATUS_W  = 2;

  // field positions inside a record
  localparam int JOB_LSB   = 0;
  localparam int CTIME_LSB = JOB_LSB + JOB_W;
  localparam int PROC_LSB  = CTIME_LSB + CTIME_W;
  localparam int PROD_LSB  = PROC_LSB + PROC_W;
  localparam int PRIO_LSB  = PROD_LSB + PROD_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST
  } state_t;

endpackage

>>> hw/rtl/slot_priority_queue.sv
// slot_priority_queue: a set of SLOTS job slots used as a priority queue. The
// job records (priority and payload) live in one synchronous memory with a
// registered read; per-slot valid bits and the occupancy count sit in flops
// and are cleared by reset, so the queue is empty right after reset with no
// clearing pass. A transaction is taken when start is high and busy is low,
// and every transaction yields exactly one result, shown on the out_ ports for
// one cycle with out_strobe high; the receiver cannot stall, so a result must
// be taken in the cycle it appears. An insert writes the lowest-numbered free
// slot and its result appears the cycle after it is taken; busy stays low, so
// inserts run at one per cycle. A pop on an empty queue also answers the next
// cycle. A pop on a non-empty queue sweeps the record memory one slot per
// cycle through its single read port, keeping the best record seen (highest
// priority, lowest slot on a tie); its result is registered once the last
// swept entry is compared in the final state, and busy is high from the
// sweep through that final state. An insert on a full queue returns status
// 1 and a pop on an empty queue status 2; only a successful pop returns job
// fields, all other results carry zeros there. out_occupancy is the slot
// count after the transaction, held at 15 when that count exceeds 15.
module slot_priority_queue #(
  parameter int SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [spq_pkg::PRIO_W-1:0]     in_job_priority,
  input  logic [spq_pkg::PROD_W-1:0]     in_producer_number,
  input  logic [spq_pkg::PROC_W-1:0]     in_process_id,
  input  logic [spq_pkg::CTIME_W-1:0]    in_compute_time,
  input  logic [spq_pkg::JOB_W-1:0]      in_job_number,

  output logic                           out_strobe,
  output logic [spq_pkg::STATUS_W-1:0]   out_status,
  output logic [spq_pkg::PRIO_W-1:0]     out_priority,
  output logic [spq_pkg::PROD_W-1:0]     out_producer,
  output logic [spq_pkg::PROC_W-1:0]     out_process,
  output logic [spq_pkg::CTIME_W-1:0]    out_compute_time,
  output logic [spq_pkg::JOB_W-1:0]      out_job_number,
  output logic [spq_pkg::OCC_W-1:0]      out_occupancy
);

  localparam int IW  = $clog2(SLOTS);      // slot index width
  localparam int CW  = $clog2(SLOTS + 1);  // count width, holds SLOTS itself
  localparam int CWX = (CW > spq_pkg::OCC_W) ? CW : spq_pkg::OCC_W;
  localparam int RW  = spq_pkg::REC_W;

  // record memory, one entry per slot
  logic [RW-1:0] mem [SLOTS];

  // control state
  spq_pkg::state_t state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    scan_idx_r, scan_idx_nxt;   // address issued to the memory
  logic             rd_pend_r, rd_pend_nxt;     // rd_data_r holds a swept entry
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;       // slot that rd_data_r came from
  logic             found_r, found_nxt;

  // sweep datapath
  logic [RW-1:0]    rd_data_r;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  logic [RW-1:0]    best_rec_r, best_rec_nxt;

  // result registers
  logic                          out_strobe_r, out_strobe_nxt;
  logic [spq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [RW-1:0]                 out_rec_r, out_rec_nxt;
  logic [spq_pkg::OCC_W-1:0]     occ_r, occ_nxt;

  // memory write port
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [RW-1:0]    mem_wdata;

  // combinational helpers
  logic [IW-1:0]    free_idx;
  logic             full;
  logic             cand_hit;
  logic [IW-1:0]    best_idx_c;
  logic [RW-1:0]    best_rec_c;
  logic [CW-1:0]    count_inc;
  logic [CW-1:0]    count_dec;
  logic [CWX-1:0]   occ_inc_ext;
  logic [CWX-1:0]   occ_dec_ext;
  logic [CWX-1:0]   occ_cur_ext;
  logic [spq_pkg::OCC_W-1:0] occ_inc;
  logic [spq_pkg::OCC_W-1:0] occ_dec;
  logic [spq_pkg::OCC_W-1:0] occ_cur;
  logic [RW-1:0]    in_rec;

  // lowest-numbered free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign full      = (count_r == CW'(SLOTS));
  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);

  // occupancy saturates at the width of the result field
  assign occ_inc_ext = CWX'(count_inc);
  assign occ_dec_ext = CWX'(count_dec);
  assign occ_cur_ext = CWX'(count_r);
  assign occ_inc = (occ_inc_ext > CWX'(15)) ? spq_pkg::OCC_W'(15) : occ_inc_ext[3:0];
  assign occ_dec = (occ_dec_ext > CWX'(15)) ? spq_pkg::OCC_W'(15) : occ_dec_ext[3:0];
  assign occ_cur = (occ_cur_ext > CWX'(15)) ? spq_pkg::OCC_W'(15) : occ_cur_ext[3:0];

  assign in_rec = {in_job_priority, in_producer_number, in_process_id,
                   in_compute_time, in_job_number};

  // a swept entry wins only on a strictly higher priority, so ties keep the
  // lower slot since the sweep runs upward
  assign cand_hit = rd_pend_r && valid_r[rd_idx_r] &&
                    (!found_r ||
                     (rd_data_r[RW-1 -: spq_pkg::PRIO_W] >
                      best_rec_r[RW-1 -: spq_pkg::PRIO_W]));
  assign best_idx_c = cand_hit ? rd_idx_r  : best_idx_r;
  assign best_rec_c = cand_hit ? rd_data_r : best_rec_r;

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_rec_nxt   = best_rec_r;
    out_strobe_nxt = 1'b0;
    status_nxt     = status_r;
    out_rec_nxt    = out_rec_r;
    occ_nxt        = occ_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx;
    mem_wdata      = in_rec;

    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) begin
          out_rec_nxt = '0;
          if (in_command == spq_pkg::CMD_INSERT) begin
            out_strobe_nxt = 1'b1;
            if (full) begin
              status_nxt = spq_pkg::ST_FULL;
              occ_nxt    = occ_cur;
            end else begin
              mem_we              = 1'b1;
              valid_nxt[free_idx] = 1'b1;
              count_nxt           = count_inc;
              status_nxt          = spq_pkg::ST_DONE;
              occ_nxt             = occ_inc;
            end
          end else if (count_r == '0) begin
            out_strobe_nxt = 1'b1;
            status_nxt     = spq_pkg::ST_EMPTY;
            occ_nxt        = '0;
          end else begin
            // start the sweep at slot 0
            state_nxt    = spq_pkg::S_SCAN;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end

      spq_pkg::S_SCAN: begin
        rd_pend_nxt  = 1'b1;
        rd_idx_nxt   = scan_idx_r;
        found_nxt    = found_r | cand_hit;
        best_idx_nxt = best_idx_c;
        best_rec_nxt = best_rec_c;
        if (scan_idx_r == IW'(SLOTS - 1)) begin
          state_nxt = spq_pkg::S_LAST;
        end else begin
          scan_idx_nxt = scan_idx_r + IW'(1);
        end
      end

      spq_pkg::S_LAST: begin
        // last swept entry is compared here and the winner retired
        valid_nxt[best_idx_c] = 1'b0;
        count_nxt             = count_dec;
        out_strobe_nxt        = 1'b1;
        status_nxt            = spq_pkg::ST_DONE;
        out_rec_nxt           = best_rec_c;
        occ_nxt               = occ_dec;
        found_nxt             = 1'b0;
        state_nxt             = spq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // record memory: writes only in idle, the sweep only reads, so the two
  // never touch the same entry in one transaction
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spq_pkg::S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_idx_r     <= rd_idx_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_rec_r <= best_rec_nxt;
    status_r   <= status_nxt;
    out_rec_r  <= out_rec_nxt;
    occ_r      <= occ_nxt;
  end

  assign busy             = (state_r != spq_pkg::S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_status       = status_r;
  assign out_priority     = out_rec_r[spq_pkg::PRIO_LSB  +: spq_pkg::PRIO_W];
  assign out_producer     = out_rec_r[spq_pkg::PROD_LSB  +: spq_pkg::PROD_W];
  assign out_process      = out_rec_r[spq_pkg::PROC_LSB  +: spq_pkg::PROC_W];
  assign out_compute_time = out_rec_r[spq_pkg::CTIME_LSB +: spq_pkg::CTIME_W];
  assign out_job_number   = out_rec_r[spq_pkg::JOB_LSB   +: spq_pkg::JOB_W];
  assign out_occupancy    = occ_r;

endmodule
